// ===== hw/rtl/eso_pkg.sv =====
`default_nettype none

package eso_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned GAIN_W = 21;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN_DT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISTURBANCE_GAIN_DT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_TRIM_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_KEEP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INNOVATION_GATE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DISTURBANCE_LIMIT = 3'd7;

  localparam logic [16:0] RST_STEP_TIME = 17'd655;
  localparam logic [16:0] RST_POSITION_GAIN = 17'd13107;
  localparam logic [20:0] RST_VELOCITY_GAIN_DT = 21'd7864;
  localparam logic [20:0] RST_DISTURBANCE_GAIN_DT = 21'd66;
  localparam logic [16:0] RST_VELOCITY_TRIM_GAIN = 17'd6554;
  localparam logic [16:0] RST_DECAY_KEEP = 17'd64553;
  localparam logic [30:0] RST_INNOVATION_GATE = 31'd9830;
  localparam logic [30:0] RST_DISTURBANCE_LIMIT = 31'd65536;

  // velocity error limit, 5.0 in q16.16
  localparam logic signed [32:0] VEL_ERR_LIMIT = 33'sd327680;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ROUND,
    ST_APPLY,
    ST_CLAMP,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_VD,
    OP_PV,
    OP_DK,
    OP_PG,
    OP_VG,
    OP_DG,
    OP_TRIM
  } op_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x[32] != x[31]) begin
      r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat39(input logic signed [38:0] x);
    logic signed [31:0] r;
    if ((&x[38:31]) || !(|x[38:31])) begin
      r = x[31:0];
    end else begin
      r = x[38] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/encoder_state_observer_top.sv =====
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       in_meas_position, in_meas_velocity
// out       output     out_valid / out_ready     out_est_*, out_innovation, out_innovation_clamped
// cfg       input      cfg_we                    cfg_index, cfg_wdata
//
// one request runs from acceptance to result through seven products on a shared
// bit-serial multiplier (21 gain bits, one per cycle), plus the clamp steps and
// the output load.
// rst_n is synchronous; it clears the estimates, the seed flag and the registers
// to their defaults. a result waiting on out_ready holds the next request at the
// output load step; a new request is taken while a result waits.
`default_nettype none

module encoder_state_observer_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [eso_pkg::DATA_W-1:0]     in_meas_position,
  input  wire logic signed [eso_pkg::DATA_W-1:0]     in_meas_velocity,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [eso_pkg::DATA_W-1:0]          out_est_position,
  output logic signed [eso_pkg::DATA_W-1:0]          out_est_velocity,
  output logic signed [eso_pkg::DATA_W-1:0]          out_est_disturbance,
  output logic signed [eso_pkg::DATA_W-1:0]          out_innovation,
  output logic                                       out_innovation_clamped,
  input  wire logic                                  cfg_we,
  input  wire logic [eso_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [eso_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  eso_pkg::state_t state_r, state_nxt;
  eso_pkg::op_t    op_r;

  logic [16:0] step_time_r;
  logic [16:0] position_gain_r;
  logic [20:0] velocity_gain_dt_r;
  logic [20:0] disturbance_gain_dt_r;
  logic [16:0] velocity_trim_gain_r;
  logic [16:0] decay_keep_r;
  logic [30:0] innovation_gate_r;
  logic [30:0] disturbance_limit_r;

  logic signed [31:0] p_r, v_r, d_r;
  logic               seeded_r;
  logic signed [31:0] mp_r, mv_r;
  logic signed [31:0] ep_r, epc_r, ev_r;
  logic               gated_r;

  // serial multiplier
  logic signed [31:0]        a_r;
  logic [eso_pkg::GAIN_W-1:0] g_r;
  logic signed [33:0]        h_r;
  logic [eso_pkg::GAIN_W-1:0] l_r;
  logic [4:0]                bit_cnt_r;
  logic signed [31:0]        q_r;

  logic               out_valid_r;
  logic signed [31:0] out_p_r, out_v_r, out_d_r, out_ep_r;
  logic               out_gated_r;

  logic               in_take;
  logic               out_load;
  logic               mul_last;
  logic signed [33:0] mul_sum;
  logic signed [38:0] rnd;
  logic signed [31:0] gate_s, dlim_s;
  logic signed [32:0] ev_diff;
  logic signed [31:0] ev_clamped;
  logic signed [31:0] a_sel;
  logic [eso_pkg::GAIN_W-1:0] g_sel;

  assign mul_last = (bit_cnt_r == 5'(eso_pkg::GAIN_W - 1));
  assign mul_sum  = h_r + (g_r[0] ? {{2{a_r[31]}}, a_r} : 34'sd0);
  assign rnd      = $signed({h_r, l_r[20:16]}) + $signed({38'd0, l_r[15]});
  assign gate_s   = $signed({1'b0, innovation_gate_r});
  assign dlim_s   = $signed({1'b0, disturbance_limit_r});
  assign ev_diff  = {mv_r[31], mv_r} - {v_r[31], v_r};

  always_comb begin
    if (ev_diff > eso_pkg::VEL_ERR_LIMIT) begin
      ev_clamped = eso_pkg::VEL_ERR_LIMIT[31:0];
    end else if (ev_diff < -eso_pkg::VEL_ERR_LIMIT) begin
      ev_clamped = 32'(-eso_pkg::VEL_ERR_LIMIT);
    end else begin
      ev_clamped = ev_diff[31:0];
    end
  end

  always_comb begin
    case (op_r)
      eso_pkg::OP_VD: begin
        a_sel = d_r;
        g_sel = {4'd0, step_time_r};
      end
      eso_pkg::OP_PV: begin
        a_sel = v_r;
        g_sel = {4'd0, step_time_r};
      end
      eso_pkg::OP_DK: begin
        a_sel = d_r;
        g_sel = {4'd0, decay_keep_r};
      end
      eso_pkg::OP_PG: begin
        a_sel = epc_r;
        g_sel = {4'd0, position_gain_r};
      end
      eso_pkg::OP_VG: begin
        a_sel = epc_r;
        g_sel = velocity_gain_dt_r;
      end
      eso_pkg::OP_DG: begin
        a_sel = epc_r;
        g_sel = disturbance_gain_dt_r;
      end
      eso_pkg::OP_TRIM: begin
        a_sel = ev_r;
        g_sel = {4'd0, velocity_trim_gain_r};
      end
      default: begin
        a_sel = '0;
        g_sel = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      eso_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = eso_pkg::ST_LOAD;
      end
      eso_pkg::ST_LOAD: begin
        state_nxt = eso_pkg::ST_MUL;
      end
      eso_pkg::ST_MUL: begin
        if (mul_last) state_nxt = eso_pkg::ST_ROUND;
      end
      eso_pkg::ST_ROUND: begin
        state_nxt = eso_pkg::ST_APPLY;
      end
      eso_pkg::ST_APPLY: begin
        if (op_r == eso_pkg::OP_DK || op_r == eso_pkg::OP_DG) begin
          state_nxt = eso_pkg::ST_CLAMP;
        end else if (op_r == eso_pkg::OP_TRIM) begin
          state_nxt = eso_pkg::ST_OUT;
        end else begin
          state_nxt = eso_pkg::ST_LOAD;
        end
      end
      eso_pkg::ST_CLAMP: begin
        state_nxt = eso_pkg::ST_LOAD;
      end
      eso_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = eso_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = eso_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      eso_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      eso_pkg::ST_OUT: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign in_take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eso_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r           <= eso_pkg::RST_STEP_TIME;
      position_gain_r       <= eso_pkg::RST_POSITION_GAIN;
      velocity_gain_dt_r    <= eso_pkg::RST_VELOCITY_GAIN_DT;
      disturbance_gain_dt_r <= eso_pkg::RST_DISTURBANCE_GAIN_DT;
      velocity_trim_gain_r  <= eso_pkg::RST_VELOCITY_TRIM_GAIN;
      decay_keep_r          <= eso_pkg::RST_DECAY_KEEP;
      innovation_gate_r     <= eso_pkg::RST_INNOVATION_GATE;
      disturbance_limit_r   <= eso_pkg::RST_DISTURBANCE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        eso_pkg::REG_STEP_TIME:           step_time_r           <= cfg_wdata[16:0];
        eso_pkg::REG_POSITION_GAIN:       position_gain_r       <= cfg_wdata[16:0];
        eso_pkg::REG_VELOCITY_GAIN_DT:    velocity_gain_dt_r    <= cfg_wdata[20:0];
        eso_pkg::REG_DISTURBANCE_GAIN_DT: disturbance_gain_dt_r <= cfg_wdata[20:0];
        eso_pkg::REG_VELOCITY_TRIM_GAIN:  velocity_trim_gain_r  <= cfg_wdata[16:0];
        eso_pkg::REG_DECAY_KEEP:          decay_keep_r          <= cfg_wdata[16:0];
        eso_pkg::REG_INNOVATION_GATE:     innovation_gate_r     <= cfg_wdata;
        eso_pkg::REG_DISTURBANCE_LIMIT:   disturbance_limit_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // estimates and sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r         <= '0;
      v_r         <= '0;
      d_r         <= '0;
      seeded_r    <= 1'b0;
      op_r        <= eso_pkg::OP_VD;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      case (state_r)
        eso_pkg::ST_IDLE: begin
          if (in_take) begin
            mp_r <= in_meas_position;
            mv_r <= in_meas_velocity;
            op_r <= eso_pkg::OP_VD;
            if (!seeded_r) begin
              p_r      <= in_meas_position;
              v_r      <= in_meas_velocity;
              seeded_r <= 1'b1;
            end
          end
        end
        eso_pkg::ST_LOAD: begin
          a_r       <= a_sel;
          g_r       <= g_sel;
          h_r       <= '0;
          l_r       <= '0;
          bit_cnt_r <= '0;
        end
        eso_pkg::ST_MUL: begin
          h_r       <= mul_sum >>> 1;
          l_r       <= {mul_sum[0], l_r[eso_pkg::GAIN_W-1:1]};
          g_r       <= g_r >> 1;
          bit_cnt_r <= bit_cnt_r + 5'd1;
        end
        eso_pkg::ST_ROUND: begin
          q_r <= eso_pkg::sat39(rnd);
        end
        eso_pkg::ST_APPLY: begin
          case (op_r)
            eso_pkg::OP_VD:   v_r <= eso_pkg::sat_add(v_r, q_r);
            eso_pkg::OP_PV:   p_r <= eso_pkg::sat_add(p_r, q_r);
            eso_pkg::OP_DK: begin
              d_r  <= q_r;
              ep_r <= eso_pkg::sat_sub(mp_r, p_r);
            end
            eso_pkg::OP_PG:   p_r <= eso_pkg::sat_add(p_r, q_r);
            eso_pkg::OP_VG:   v_r <= eso_pkg::sat_add(v_r, q_r);
            eso_pkg::OP_DG:   d_r <= eso_pkg::sat_add(d_r, q_r);
            eso_pkg::OP_TRIM: v_r <= eso_pkg::sat_add(v_r, q_r);
            default: begin
            end
          endcase
          if (op_r != eso_pkg::OP_TRIM && op_r != eso_pkg::OP_DK &&
              op_r != eso_pkg::OP_DG) begin
            op_r <= eso_pkg::op_t'(op_r + 3'd1);
          end
        end
        eso_pkg::ST_CLAMP: begin
          if (op_r == eso_pkg::OP_DK) begin
            // gate the innovation
            gated_r <= (ep_r > gate_s) || (ep_r < -gate_s);
            if (ep_r > gate_s) begin
              epc_r <= gate_s;
            end else if (ep_r < -gate_s) begin
              epc_r <= -gate_s;
            end else begin
              epc_r <= ep_r;
            end
          end else begin
            // disturbance limit and velocity error
            if (d_r > dlim_s) begin
              d_r <= dlim_s;
            end else if (d_r < -dlim_s) begin
              d_r <= -dlim_s;
            end
            ev_r <= ev_clamped;
          end
          op_r <= eso_pkg::op_t'(op_r + 3'd1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_p_r     <= p_r;
      out_v_r     <= v_r;
      out_d_r     <= d_r;
      out_ep_r    <= ep_r;
      out_gated_r <= gated_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_est_position       = out_p_r;
  assign out_est_velocity       = out_v_r;
  assign out_est_disturbance    = out_d_r;
  assign out_innovation         = out_ep_r;
  assign out_innovation_clamped = out_gated_r;

endmodule

`default_nettype wire
